@@ sv/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg: shared definitions for the multi-stack shared-pool core
// Item types, operation and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned NUM_STACKS_DEF = 8;
  localparam int unsigned POOL_DEPTH_DEF = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [INDEX_W-1:0]        stack_index;
    logic signed [VALUE_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STAT_W-1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/msp_stream_if.sv @@
// ----------------------------------------------------------------------------
// msp_stream_if: valid/ready channel
// Carries one item per handshake; source drives valid and data, sink ready.
// ----------------------------------------------------------------------------
interface msp_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/msp_ctrl.sv @@
// ----------------------------------------------------------------------------
// msp_ctrl: operation sequencer
// Two-state controller: capture an item, then execute it once the output
// register is free.
// ----------------------------------------------------------------------------
module msp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  msp_pkg::dp_status_t sts_i,
  output logic                in_ready_o,
  output msp_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.capture = in_ready_o && in_valid_i;
  assign cmd_o.exec    = (state_q == S_EXEC) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.exec) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/msp_datapath.sv @@
// ----------------------------------------------------------------------------
// msp_datapath: stack tops, free list and node memory
// Holds the top pointers, the free-list head, the fresh-node counter, the
// node value/link memories and the result register.
// ----------------------------------------------------------------------------
module msp_datapath #(
  parameter int unsigned NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int unsigned POOL_DEPTH = msp_pkg::POOL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = msp_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msp_pkg::ctrl_cmd_t  cmd_i,
  output msp_pkg::dp_status_t sts_o,
  input  msp_pkg::in_item_t   in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output msp_pkg::out_item_t  out_data_o
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned PW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] NULL_PTR = PW'(POOL_DEPTH);

  function automatic logic [PW-1:0] clamp_ptr(input logic [PW-1:0] p);
    return (p > NULL_PTR) ? NULL_PTR : p;
  endfunction

  logic [PW-1:0] stack_top_q [NUM_STACKS];
  logic [PW-1:0] free_head_q, fresh_q;
  logic          out_valid_q;
  msp_pkg::out_item_t out_data_q;

  logic [msp_pkg::FUNC_W-1:0] func_q;
  logic [SW-1:0]              idx_q;
  logic                       idx_ok_q;
  logic [DATA_WIDTH-1:0]      value_q;
  logic [PW-1:0]              top_q;

  logic [DATA_WIDTH-1:0] value_mem [POOL_DEPTH];
  logic [PW-1:0]         link_mem  [POOL_DEPTH];
  logic [DATA_WIDTH-1:0] rd_value_q;
  logic [PW-1:0]         rd_link_q;

  // capture side
  logic [SW-1:0] in_idx;
  logic          in_idx_ok;
  logic [PW-1:0] in_top, rd_ptr;
  logic          rd_en;

  assign in_idx    = SW'(in_data_i.stack_index);
  assign in_idx_ok = int'(in_data_i.stack_index) < NUM_STACKS;
  assign in_top    = in_idx_ok ? clamp_ptr(stack_top_q[in_idx]) : NULL_PTR;
  assign rd_ptr    = (in_data_i.func == msp_pkg::FUNC_PUSH) ? free_head_q : in_top;
  assign rd_en     = cmd_i.capture && (rd_ptr < NULL_PTR);

  // execute side
  logic          take_ok, take_free;
  logic [PW-1:0] take_ptr;
  logic          top_ok;
  logic          wr_val_en, wr_link_en;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_link;
  logic signed [msp_pkg::VALUE_W-1:0] res_value;
  logic [msp_pkg::STAT_W-1:0]         res_status;

  always_comb begin
    take_free = free_head_q < NULL_PTR;
    take_ok   = idx_ok_q && (take_free || (fresh_q < NULL_PTR));
    take_ptr  = take_free ? free_head_q : fresh_q;
    top_ok    = top_q < NULL_PTR;
    wr_val_en  = 1'b0;
    wr_link_en = 1'b0;
    wr_addr    = AW'(take_ptr);
    wr_link    = top_q;
    res_value  = '0;
    res_status = msp_pkg::ST_OK;
    case (func_q)
      msp_pkg::FUNC_PUSH: begin
        if (take_ok) begin
          wr_val_en  = cmd_i.exec;
          wr_link_en = cmd_i.exec;
        end else begin
          res_status = msp_pkg::ST_FULL;
        end
      end
      msp_pkg::FUNC_POP, msp_pkg::FUNC_PEEK: begin
        if (top_ok) begin
          res_value = msp_pkg::VALUE_W'($signed(rd_value_q));
          if (func_q == msp_pkg::FUNC_POP) begin
            wr_link_en = cmd_i.exec;
            wr_addr    = AW'(top_q);
            wr_link    = free_head_q;
          end
        end else begin
          res_value  = '1;
          res_status = msp_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) stack_top_q[i] <= NULL_PTR;
      free_head_q <= NULL_PTR;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
        if (func_q == msp_pkg::FUNC_PUSH && take_ok) begin
          stack_top_q[idx_q] <= take_ptr;
          if (take_free) free_head_q <= clamp_ptr(rd_link_q);
          else           fresh_q     <= fresh_q + PW'(1);
        end else if (func_q == msp_pkg::FUNC_POP && top_ok) begin
          stack_top_q[idx_q] <= clamp_ptr(rd_link_q);
          free_head_q        <= top_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= in_data_i.func;
      idx_q    <= in_idx;
      idx_ok_q <= in_idx_ok;
      value_q  <= DATA_WIDTH'(in_data_i.push_value);
      top_q    <= in_top;
    end
    if (cmd_i.exec) begin
      out_data_q.result_value <= res_value;
      out_data_q.status       <= res_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_value_q <= value_mem[AW'(rd_ptr)];
      rd_link_q  <= link_mem[AW'(rd_ptr)];
    end
    if (wr_val_en) value_mem[wr_addr] <= value_q;
    if (wr_link_en) link_mem[wr_addr] <= wr_link;
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

@@ sv/multi_stack_shared_pool_core.sv @@
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_core: linked stacks over a shared node pool
// NUM_STACKS LIFO stacks draw nodes from one pool of POOL_DEPTH entries.
//
// in_i carries one operation per item: func (push, pop, peek), stack_index
// and push_value. out_o returns exactly one item per operation: result_value
// and status (ok, stack empty, pool full). Pop/peek of an empty stack give -1
// with status empty; a push with no node left gives status full and changes
// nothing.
// Flow: one item is in flight at a time, so a new item is taken only after
// the last one has executed. The node memory sets this: the top or free-list
// pointer addresses it in the accept cycle, and its registered read data is
// used when the item executes, once the output register is free.
// A new item is taken while a finished result still waits in the output
// register; if out_o stalls, execution of that item holds until the result
// is taken. Reset clears all tops, the free list and the fresh-node counter
// at once; node memory needs no clearing and items are taken straight away.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_core #(
  parameter int unsigned NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int unsigned POOL_DEPTH = msp_pkg::POOL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = msp_pkg::DATA_WIDTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  msp_stream_if.sink   in_i,
  msp_stream_if.source out_o
);

  msp_pkg::ctrl_cmd_t  cmd;
  msp_pkg::dp_status_t sts;
  logic                in_ready;

  msp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  msp_datapath #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item taken while one is in flight");

  a_exec_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_o.valid)
    else $error("executed item left no result");

  a_no_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.capture && cmd.exec))
    else $error("capture and execute in the same cycle");

  a_exec_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_o.valid || out_o.ready))
    else $error("result overwritten before it was taken");

endmodule
